[rtl/priority_voice_allocator_top_assert.svh]
// Assertion macros for the priority voice allocator.
`ifndef PRIORITY_VOICE_ALLOCATOR_TOP_ASSERT_SVH
`define PRIORITY_VOICE_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the cycle after the antecedent.
`define PVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("voice allocator check failed");
// The consequent must hold in the same cycle as the antecedent.
`define PVA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("voice allocator check failed");
`else
`define PVA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define PVA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/pva_pkg.sv]
// Shared types, constants and helpers of the priority voice allocator.
package pva_pkg;

  // Size of the voice pool and the derived widths.
  localparam int Voices = 32;
  localparam int IdxW   = (Voices > 1) ? $clog2(Voices) : 1;
  localparam int CntW   = $clog2(Voices + 1);

  // Transaction kinds.
  localparam logic KindRequest = 1'b0;
  localparam logic KindRelease = 1'b1;

  // Result status codes.
  localparam logic StatusOk   = 1'b0;
  localparam logic StatusNone = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StScan = 2'b10
  } state_e;

  // Search record handed from cell to cell along the chain.
  typedef struct packed {
    logic            free_hit;
    logic [IdxW-1:0] free_idx;
    logic            low_hit;
    logic [IdxW-1:0] low_idx;
    logic [15:0]     low_sound;
    logic            eq_hit;
    logic [IdxW-1:0] eq_idx;
    logic [15:0]     eq_sound;
    logic [31:0]     eq_life;
  } cand_t;

  // Write command broadcast to all cells at the end of a transaction.
  typedef struct packed {
    logic            set;
    logic            clr;
    logic [IdxW-1:0] idx;
    logic [7:0]      prio;
    logic [15:0]     sound;
    logic [31:0]     start;
  } wr_t;

  // Low five bits of a voice index, zero-extended when the index is narrower.
  function automatic logic [4:0] idx_field(logic [IdxW-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[4:0];
  endfunction

endpackage

[rtl/pva_cell.sv]
// One voice cell: holds a voice record and refines the search record passing by.
module pva_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [pva_pkg::IdxW-1:0] cell_idx_i,
  input  logic [7:0]               req_prio_i,
  input  logic [31:0]              req_now_i,
  input  pva_pkg::cand_t           cand_i,
  input  pva_pkg::wr_t             wr_i,
  output pva_pkg::cand_t           cand_o
);

  logic           busy_q;
  logic [7:0]     prio_q;
  logic [31:0]    start_q;
  logic [15:0]    sound_q;
  logic [31:0]    life;
  logic           hit;
  pva_pkg::cand_t cand_d, cand_q;

  assign hit  = (wr_i.idx == cell_idx_i);
  assign life = req_now_i - start_q;

  // Update the search record with this voice.
  always_comb begin
    cand_d = cand_i;
    if (!cand_i.free_hit && !busy_q) begin
      cand_d.free_hit = 1'b1;
      cand_d.free_idx = cell_idx_i;
    end
    if (busy_q && !cand_i.low_hit && (prio_q > req_prio_i)) begin
      cand_d.low_hit   = 1'b1;
      cand_d.low_idx   = cell_idx_i;
      cand_d.low_sound = sound_q;
    end
    if (busy_q && (prio_q == req_prio_i) && ($signed(life) > $signed(cand_i.eq_life))) begin
      cand_d.eq_hit   = 1'b1;
      cand_d.eq_idx   = cell_idx_i;
      cand_d.eq_sound = sound_q;
      cand_d.eq_life  = life;
    end
  end

  // The busy flag is the only control state of the cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (wr_i.set && hit) begin
      busy_q <= 1'b1;
    end else if (wr_i.clr && hit) begin
      busy_q <= 1'b0;
    end
  end

  // Voice record and the registered hand-off to the next cell.
  always_ff @(posedge clk_i) begin
    if (wr_i.set && hit) begin
      prio_q  <= wr_i.prio;
      start_q <= wr_i.start;
      sound_q <= wr_i.sound;
    end
    cand_q <= cand_d;
  end

  assign cand_o = cand_q;

endmodule

[rtl/priority_voice_allocator_top.sv]
// Top level of the priority voice allocator: controller and chain of voice cells.
//
//  Channel   Handshake          Fields
//  ------    ---------          ------
//  command   start / busy       kind, request_priority, sound_handle, now_time, release_voice
//  result    done_o strobe      status, voice_index, stolen, evicted_sound
//  config    cfg_we_i           cfg_wdata_i (steal_enable)
//
// In a request the search record walks the chain of voice cells one cell per cycle,
// then the winner is written back. Reset frees every voice and clears steal_enable.
// The result strobe lasts one cycle; the receiver cannot stall it.
`include "priority_voice_allocator_top_assert.svh"

module priority_voice_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [7:0]  request_priority_i,
  input  logic [15:0] sound_handle_i,
  input  logic [31:0] now_time_i,
  input  logic [4:0]  release_voice_i,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  output logic        done_o,
  output logic        status_o,
  output logic [4:0]  voice_index_o,
  output logic        stolen_o,
  output logic [15:0] evicted_sound_o
);

  pva_pkg::state_e             state_d, state_q;
  logic [pva_pkg::CntW-1:0]    cnt_d, cnt_q;
  logic                        steal_q;
  logic                        kind_q;
  logic [7:0]                  prio_q;
  logic [15:0]                 sound_q;
  logic [31:0]                 now_q;
  logic [4:0]                  rel_q;
  logic                        accept;
  logic                        finish;
  pva_pkg::cand_t              cand_w [pva_pkg::Voices+1];
  pva_pkg::cand_t              last;
  pva_pkg::wr_t                wr;
  logic                        res_status;
  logic [pva_pkg::IdxW-1:0]    res_idx;
  logic                        res_stolen;
  logic [15:0]                 res_evicted;

  assign busy   = (state_q == pva_pkg::StScan);
  assign accept = start && !busy;
  assign finish = busy && ((kind_q == pva_pkg::KindRelease) ||
                           (cnt_q == pva_pkg::CntW'(pva_pkg::Voices)));

  // Controller: wait for a transaction, then count the chain latency.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      pva_pkg::StIdle: begin
        if (start) begin
          state_d = pva_pkg::StScan;
          cnt_d   = '0;
        end
      end
      pva_pkg::StScan: begin
        cnt_d = cnt_q + pva_pkg::CntW'(1);
        if (finish) begin
          state_d = pva_pkg::StIdle;
        end
      end
      default: begin
        state_d = pva_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pva_pkg::StIdle;
      cnt_q   <= '0;
      steal_q <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_o  <= finish;
      if (cfg_we_i) begin
        steal_q <= cfg_wdata_i;
      end
    end
  end

  // Capture the transaction fields.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      prio_q  <= request_priority_i;
      sound_q <= sound_handle_i;
      now_q   <= now_time_i;
      rel_q   <= release_voice_i;
    end
  end

  // Chain of voice cells, fed with an empty search record.
  assign cand_w[0] = '0;

  for (genvar k = 0; k < pva_pkg::Voices; k++) begin : g_cell
    pva_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (pva_pkg::IdxW'(k)),
      .req_prio_i (prio_q),
      .req_now_i  (now_q),
      .cand_i     (cand_w[k]),
      .wr_i       (wr),
      .cand_o     (cand_w[k+1])
    );
  end

  assign last = cand_w[pva_pkg::Voices];

  // Pick the winner and form the write-back and the result.
  always_comb begin
    wr          = '0;
    wr.prio     = prio_q;
    wr.sound    = sound_q;
    wr.start    = now_q;
    res_status  = pva_pkg::StatusOk;
    res_idx     = '0;
    res_stolen  = 1'b0;
    res_evicted = '0;
    if (kind_q == pva_pkg::KindRelease) begin
      wr.clr = finish && (32'(rel_q) < 32'(pva_pkg::Voices));
      wr.idx = pva_pkg::IdxW'(rel_q);
    end else if (last.free_hit) begin
      wr.set  = finish;
      wr.idx  = last.free_idx;
      res_idx = last.free_idx;
    end else if (steal_q && last.low_hit) begin
      wr.set      = finish;
      wr.idx      = last.low_idx;
      res_idx     = last.low_idx;
      res_stolen  = 1'b1;
      res_evicted = last.low_sound;
    end else if (steal_q && last.eq_hit) begin
      wr.set      = finish;
      wr.idx      = last.eq_idx;
      res_idx     = last.eq_idx;
      res_stolen  = 1'b1;
      res_evicted = last.eq_sound;
    end else begin
      res_status = pva_pkg::StatusNone;
    end
  end

  // Result registers, shown for one cycle under done_o.
  always_ff @(posedge clk_i) begin
    if (finish) begin
      status_o        <= res_status;
      voice_index_o   <= pva_pkg::idx_field(res_idx);
      stolen_o        <= res_stolen;
      evicted_sound_o <= res_evicted;
    end
  end

  // Checks on the controller and the result.
  `PVA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy)
  `PVA_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `PVA_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  `PVA_ASSERT_NOW(a_stolen_ok, clk_i, rst_ni, done_o && stolen_o, status_o == pva_pkg::StatusOk)

endmodule
